// ===== rtl/olist_pkg.sv =====
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types, codes and helpers for the ordered list core.
// ----------------------------------------------------------------------------
`default_nettype none

package olist_pkg;

	localparam int OLIST_CAPACITY = 128;
	localparam int VALUE_W        = 32;
	localparam int POS_W          = 8;
	localparam int GRP            = 8;   // match bits examined per scan cycle

	// operation codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_FULL   = 3'd1;
	localparam logic [2:0] ST_EMPTY  = 3'd2;
	localparam logic [2:0] ST_BADPOS = 3'd3;
	localparam logic [2:0] ST_MISS   = 3'd4;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic               ins;    // insert: shift up at/above pos, load value at pos
		logic               del;    // delete: shift down at/above pos
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] value;  // insert data and search key
	} cell_ctl_t;

	// lowest set bit of one scan group
	function automatic logic [$clog2(GRP)-1:0] lowest_set(input logic [GRP-1:0] v);
		logic [$clog2(GRP)-1:0] r;
		r = '0;
		for (int i = GRP - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = ($clog2(GRP))'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/olist_cell.sv =====
// ----------------------------------------------------------------------------
// olist_cell
// One list slot: holds an entry, shifts with its neighbors, compares a key.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_cell #(
	parameter int CAPACITY = olist_pkg::OLIST_CAPACITY,
	parameter int INDEX    = 0
) (
	input  wire                              clk,
	input  wire olist_pkg::cell_ctl_t        ctl,
	input  wire [$clog2(CAPACITY+1)-1:0]     count,
	input  wire [olist_pkg::VALUE_W-1:0]     prev_entry,  // entry of slot INDEX-1
	input  wire [olist_pkg::VALUE_W-1:0]     next_entry,  // entry of slot INDEX+1
	output logic [olist_pkg::VALUE_W-1:0]    entry,
	output logic                             hit
);
	import olist_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [PW-1:0] MY_IDX = PW'(INDEX);

	logic [VALUE_W-1:0] entry_q;
	logic [PW-1:0]      pos_w;

	assign pos_w = PW'(ctl.pos);
	assign entry = entry_q;
	assign hit   = (entry_q == ctl.value) && (PW'(count) > MY_IDX);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (MY_IDX == pos_w) begin
				entry_q <= ctl.value;
			end else if (MY_IDX > pos_w) begin
				entry_q <= prev_entry;
			end
		end else if (ctl.del && (MY_IDX >= pos_w)) begin
			entry_q <= next_entry;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ordered_list_insert_delete_search_core.sv =====
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_search_core
// Positional list of 32-bit values with insert, delete and search.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd/value/position with start high; the item is
//   taken at a clock edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with status, found_index and
//   count. There is no back-pressure: the receiver must take it then.
// Timing:
//   Insert, delete and the unused code give their result on the cycle
//   after acceptance; busy stays low, one item per cycle.
//   Search compares all cells at once on the accept edge, then scans the
//   match vector GRP bits per cycle, stopping at the first hit or after the
//   last group. busy is high from the accept edge until the result cycle,
//   and no new item is taken meanwhile.
// Reset:
//   arst_n clears the count and control; entry contents are not cleared,
//   slots at or above the count are never observed.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_insert_delete_search_core #(
	parameter int CAPACITY = olist_pkg::OLIST_CAPACITY
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire [1:0]                           cmd,
	input  wire signed [olist_pkg::VALUE_W-1:0] value,
	input  wire [olist_pkg::POS_W-1:0]          position,
	output logic                                done,
	output logic [2:0]                          status,
	output logic [6:0]                          found_index,
	output logic [7:0]                          count
);
	import olist_pkg::*;

	localparam int CW   = $clog2(CAPACITY + 1);          // count width
	localparam int PW   = (CW > POS_W) ? CW : POS_W;     // compare width
	localparam int NGRP = (CAPACITY + GRP - 1) / GRP;    // scan groups
	localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int MW   = NGRP * GRP;                    // padded match width

	// control / result registers
	logic          busy_q;
	logic          done_q;
	logic [2:0]    status_q;
	logic [CW-1:0] found_q;
	logic [CW-1:0] count_q;
	logic [GW-1:0] grp_q;
	logic [MW-1:0] match_q;

	logic          accept;
	logic [PW-1:0] pos_w;
	logic [PW-1:0] cnt_w;
	logic          is_full;
	logic          is_empty;
	logic          ins_ok;
	logic          del_ok;
	cell_ctl_t     ctl;

	logic [VALUE_W-1:0] entry_w [CAPACITY];
	logic [MW-1:0]      hit_w;

	logic [GRP-1:0] low_grp;
	logic [CW-1:0]  scan_idx;

	assign accept   = start && !busy_q;
	assign pos_w    = PW'(position);
	assign cnt_w    = PW'(count_q);
	assign is_full  = (cnt_w >= PW'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign ins_ok   = accept && (cmd == CMD_INSERT) && !is_full && (pos_w <= cnt_w);
	assign del_ok   = accept && (cmd == CMD_DELETE) && !is_empty && (pos_w < cnt_w);

	always_comb begin
		ctl.ins   = ins_ok;
		ctl.del   = del_ok;
		ctl.pos   = position;
		ctl.value = value;
	end

	// ---- the row of cells: each slot talks only to its two neighbors
	for (genvar i = 0; i < MW; i++) begin : g_slot
		if (i < CAPACITY) begin : g_cell
			logic [VALUE_W-1:0] prev_w;
			logic [VALUE_W-1:0] next_w;
			if (i == 0) begin : g_first
				assign prev_w = '0;
			end else begin : g_mid_p
				assign prev_w = entry_w[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign next_w = entry_w[i];
			end else begin : g_mid_n
				assign next_w = entry_w[i+1];
			end
			olist_cell #(
				.CAPACITY (CAPACITY),
				.INDEX    (i)
			) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.count      (count_q),
				.prev_entry (prev_w),
				.next_entry (next_w),
				.entry      (entry_w[i]),
				.hit        (hit_w[i])
			);
		end else begin : g_pad
			assign hit_w[i] = 1'b0;
		end
	end

	// ---- search scan: look at the bottom group, shift the vector down
	assign low_grp  = match_q[GRP-1:0];
	assign scan_idx = CW'({grp_q, lowest_set(low_grp)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
			grp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				unique case (cmd)
					CMD_INSERT: begin
						done_q <= 1'b1;
						if (ins_ok) begin
							count_q <= count_q + CW'(1);
						end
					end
					CMD_DELETE: begin
						done_q <= 1'b1;
						if (del_ok) begin
							count_q <= count_q - CW'(1);
						end
					end
					CMD_SEARCH: begin
						busy_q <= 1'b1;
						grp_q  <= '0;
					end
					default: begin
						done_q <= 1'b1;
					end
				endcase
			end else if (busy_q) begin
				if ((|low_grp) || (grp_q == GW'(NGRP - 1))) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					grp_q <= grp_q + GW'(1);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			found_q <= '0;
			match_q <= hit_w;
			unique case (cmd)
				CMD_INSERT: begin
					priority if (is_full) begin
						status_q <= ST_FULL;
					end else if (pos_w > cnt_w) begin
						status_q <= ST_BADPOS;
					end else begin
						status_q <= ST_OK;
					end
				end
				CMD_DELETE: begin
					priority if (is_empty) begin
						status_q <= ST_EMPTY;
					end else if (pos_w >= cnt_w) begin
						status_q <= ST_BADPOS;
					end else begin
						status_q <= ST_OK;
					end
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end else if (busy_q) begin
			match_q <= match_q >> GRP;
			if (|low_grp) begin
				status_q <= ST_OK;
				found_q  <= scan_idx;
			end else begin
				status_q <= ST_MISS;
				found_q  <= '0;
			end
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign status      = status_q;
	assign found_index = 7'(found_q);
	assign count       = 8'(count_q);

endmodule

`default_nettype wire
